// ----- hdl/bpseq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpseq_pkg
// Shared types and constants for the buzzer pattern sequencer: request
// payload layout, control register indexes and their reset values.
// ----------------------------------------------------------------------------
package bpseq_pkg;

   localparam int PATTERN_WIDTH   = 32;
   localparam int TIME_WIDTH      = 32;
   localparam int INTERVAL_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SINGLE_PATTERN  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARMING_PATTERN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EKF_BAD_PATTERN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_PATTERN  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_INTERVAL_MS = 3'd4;

   // Register reset values
   localparam logic [PATTERN_WIDTH-1:0]  SINGLE_PATTERN_RESET  = 32'h8000_0000;
   localparam logic [PATTERN_WIDTH-1:0]  ARMING_PATTERN_RESET  = 32'hFFFF_FFFC;
   localparam logic [PATTERN_WIDTH-1:0]  EKF_BAD_PATTERN_RESET = 32'hE750_0000;
   localparam logic [PATTERN_WIDTH-1:0]  DOUBLE_PATTERN_RESET  = 32'hA000_0000;
   localparam logic [INTERVAL_WIDTH-1:0] MIN_INTERVAL_RESET    = 16'd3400;

   // A pattern stops playing this long after its start
   localparam logic [TIME_WIDTH-1:0] PLAY_SPAN_MS = 32'd3200;
   localparam int SPAN_WIDTH = 12;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  arm_refused;
      logic                  armed;
      logic                  ekf_bad;
      logic                  lost_alarm;
      logic                  battery_failsafe;
   } req_payload_type;

endpackage

// ----- hdl/bpseq_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpseq channels
// Valid/ready channel interfaces for update requests and buzzer responses.
// ----------------------------------------------------------------------------
interface bpseq_req_if;
   import bpseq_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bpseq_rsp_if;
   logic valid;
   logic ready;
   logic buzzer_level;

   modport source (output valid, output buzzer_level, input ready);
   modport sink   (input valid, input buzzer_level, output ready);
endinterface

// ----- hdl/buzzer_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Picks a buzz pattern per update request and plays it one bit per period.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one update request: millisecond timestamp plus five
//   status flags. rsp_if returns one buzzer level for every request, in order.
//   csr_* writes the four pattern registers and the minimum start interval;
//   write them only while no request is in flight.
//   An accepted request is held in the input register, then passes the
//   decision/playback logic into the response register, which drives
//   rsp_if. Throughput: one request per cycle while the response side
//   does not stall, set by the single decision stage that reads and
//   updates the playback state for each request.
//   The bit index is taken from the elapsed time by a constant reciprocal
//   multiply in that same stage.
//   Reset: nothing plays, buzzer off, latched armed and ekf flags cleared,
//   registers back to their defaults, both channel stages empty.
//   Stall: when rsp_if.ready is low the response register holds; the input
//   register still fills, and req_if.ready drops once both stages are full.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer #(
   parameter int BIT_TIME_MS = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bpseq_req_if.sink                            req_if,
   bpseq_rsp_if.source                          rsp_if,
   input  logic                                 csr_write_enable,
   input  logic [bpseq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bpseq_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import bpseq_pkg::*;

   // Reciprocal of the bit period, exact for every elapsed time below span
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_WIDTH = RECIP_SHIFT + 1;
   localparam longint RECIP_VALUE = ((64'd1 << RECIP_SHIFT) + BIT_TIME_MS - 1) / BIT_TIME_MS;
   localparam logic [RECIP_WIDTH-1:0] RECIP = RECIP_WIDTH'(RECIP_VALUE);
   localparam int PROD_WIDTH = SPAN_WIDTH + RECIP_WIDTH;
   localparam int INDEX_WIDTH = PROD_WIDTH - RECIP_SHIFT;

   // Control registers
   logic [PATTERN_WIDTH-1:0]  single_pattern_ff;
   logic [PATTERN_WIDTH-1:0]  arming_pattern_ff;
   logic [PATTERN_WIDTH-1:0]  ekf_bad_pattern_ff;
   logic [PATTERN_WIDTH-1:0]  double_pattern_ff;
   logic [INTERVAL_WIDTH-1:0] min_interval_ff;

   // Stage registers
   logic            in_valid_ff;
   req_payload_type in_payload_ff;
   logic            rsp_valid_ff;
   logic            rsp_level_ff;

   // Playback state
   logic [PATTERN_WIDTH-1:0] active_pattern_ff, active_pattern_in;
   logic [TIME_WIDTH-1:0]    start_time_ff, start_time_in;
   logic                     seen_armed_ff, seen_armed_in;
   logic                     seen_ekf_bad_ff, seen_ekf_bad_in;
   logic                     tone_on_ff, tone_on_in;

   logic                     advance;
   logic [TIME_WIDTH-1:0]    elapsed;
   logic                     start;
   logic [PATTERN_WIDTH-1:0] chosen;
   logic [TIME_WIDTH-1:0]    play_elapsed;
   logic [PROD_WIDTH-1:0]    product;
   logic [INDEX_WIDTH-1:0]   bit_index;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.buzzer_level = rsp_level_ff;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         single_pattern_ff  <= SINGLE_PATTERN_RESET;
         arming_pattern_ff  <= ARMING_PATTERN_RESET;
         ekf_bad_pattern_ff <= EKF_BAD_PATTERN_RESET;
         double_pattern_ff  <= DOUBLE_PATTERN_RESET;
         min_interval_ff    <= MIN_INTERVAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SINGLE_PATTERN:  single_pattern_ff  <= csr_data;
            CSR_ARMING_PATTERN:  arming_pattern_ff  <= csr_data;
            CSR_EKF_BAD_PATTERN: ekf_bad_pattern_ff <= csr_data;
            CSR_DOUBLE_PATTERN:  double_pattern_ff  <= csr_data;
            CSR_MIN_INTERVAL_MS: min_interval_ff    <= csr_data[INTERVAL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Choose a pattern to start, then play the active one
   always_comb begin
      elapsed         = in_payload_ff.now_ms - start_time_ff;
      seen_armed_in   = seen_armed_ff;
      seen_ekf_bad_in = seen_ekf_bad_ff;
      start           = 1'b0;
      chosen          = single_pattern_ff;

      priority if (in_payload_ff.arm_refused) begin
         start = 1'b1;
      end else if (elapsed < {16'd0, min_interval_ff}) begin
         start = 1'b0;
      end else if (in_payload_ff.armed != seen_armed_ff) begin
         seen_armed_in = in_payload_ff.armed;
         start         = 1'b1;
         chosen        = in_payload_ff.armed ? arming_pattern_ff : single_pattern_ff;
      end else if (in_payload_ff.ekf_bad != seen_ekf_bad_ff) begin
         seen_ekf_bad_in = in_payload_ff.ekf_bad;
         start           = in_payload_ff.ekf_bad;
         chosen          = ekf_bad_pattern_ff;
      end else if (in_payload_ff.lost_alarm) begin
         start  = 1'b1;
         chosen = double_pattern_ff;
      end else if (in_payload_ff.battery_failsafe) begin
         start = 1'b1;
      end

      active_pattern_in = start ? chosen : active_pattern_ff;
      start_time_in     = start ? in_payload_ff.now_ms : start_time_ff;
      play_elapsed      = start ? '0 : elapsed;

      product   = PROD_WIDTH'(play_elapsed[SPAN_WIDTH-1:0]) * PROD_WIDTH'(RECIP);
      bit_index = product[PROD_WIDTH-1:RECIP_SHIFT];

      tone_on_in = tone_on_ff;
      if (active_pattern_in != '0) begin
         if (play_elapsed >= PLAY_SPAN_MS) begin
            tone_on_in        = 1'b0;
            active_pattern_in = '0;
         end else if (bit_index[INDEX_WIDTH-1:5] != '0) begin
            tone_on_in = 1'b0;
         end else begin
            tone_on_in = active_pattern_in[~bit_index[4:0]];
         end
      end
   end

   // Hold the input request until the decision stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_payload_ff <= req_if.payload;
      end
   end

   // Advance playback state and load the response
   always_ff @(posedge clock) begin
      if (reset) begin
         active_pattern_ff <= '0;
         start_time_ff     <= '0;
         seen_armed_ff     <= 1'b0;
         seen_ekf_bad_ff   <= 1'b0;
         tone_on_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (advance) begin
            active_pattern_ff <= active_pattern_in;
            start_time_ff     <= start_time_in;
            seen_armed_ff     <= seen_armed_in;
            seen_ekf_bad_ff   <= seen_ekf_bad_in;
            tone_on_ff        <= tone_on_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_level_ff <= tone_on_in;
      end
   end

endmodule

// ----- tb/tb_buzzer_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buzzer_pattern_sequencer
// Self-checking bench for the buzzer pattern sequencer. A queue-fed driver
// sends update requests. A clocked monitor predicts the buzzer level of each
// accepted request and compares it with the returned one, in order. A
// directed walk runs first; then each phase reprograms the pattern registers
// and the start interval while the block is idle and runs a randomized update
// stream, with random gaps on one, both or neither of the channels.
// ----------------------------------------------------------------------------
module tb_buzzer_pattern_sequencer;
   import bpseq_pkg::*;

   localparam int BIT_PERIOD_MS  = 100;
   localparam int CLOCK_HALF_NS  = 5;
   localparam int RESET_CYCLES   = 5;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_UPDATES  = 175;
   localparam int SETTLE_CYCLES  = 4;

   // Indexes past the last register; writes there must be ignored
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_FIRST = 3'd5;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   bpseq_req_if req_ch ();
   bpseq_rsp_if rsp_ch ();

   buzzer_pattern_sequencer #(
      .BIT_TIME_MS(BIT_PERIOD_MS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the control registers
   logic [PATTERN_WIDTH-1:0]  cfg_single;
   logic [PATTERN_WIDTH-1:0]  cfg_arming;
   logic [PATTERN_WIDTH-1:0]  cfg_ekf_bad;
   logic [PATTERN_WIDTH-1:0]  cfg_double;
   logic [INTERVAL_WIDTH-1:0] cfg_min_gap;

   // Shadow copy of the playback state
   logic [PATTERN_WIDTH-1:0] shadow_pattern;
   logic [TIME_WIDTH-1:0]    play_start;
   logic                     armed_latch;
   logic                     ekf_latch;
   logic                     tone_level;

   req_payload_type updates_pending[$];
   logic            levels_due[$];

   int items_sent;
   int rsp_seen;
   int mismatches;
   int quiet_cycles;
   int gap_left;
   int stall_left;
   int idle_odds;
   int stall_odds;
   int phases_run;
   logic req_taken;

   // Clock
   initial clock = 1'b0;
   always #(CLOCK_HALF_NS) clock = ~clock;

   // Predict the buzzer level for one update and advance the shadow state
   function automatic logic predict_buzzer_level(input req_payload_type u);
      logic [TIME_WIDTH-1:0]    elapsed;
      logic [TIME_WIDTH-1:0]    slot;
      logic [PATTERN_WIDTH-1:0] pick;
      logic                     launch;
      launch  = 1'b0;
      pick    = '0;
      elapsed = u.now_ms - play_start;
      if (u.arm_refused) begin
         launch = 1'b1;
         pick   = cfg_single;
      end else if (elapsed >= TIME_WIDTH'(cfg_min_gap)) begin
         if (u.armed != armed_latch) begin
            armed_latch = u.armed;
            launch      = 1'b1;
            pick        = u.armed ? cfg_arming : cfg_single;
         end else if (u.ekf_bad != ekf_latch) begin
            // a fall still ends the selection, only a rise plays
            ekf_latch = u.ekf_bad;
            if (u.ekf_bad) begin
               launch = 1'b1;
               pick   = cfg_ekf_bad;
            end
         end else if (u.lost_alarm) begin
            launch = 1'b1;
            pick   = cfg_double;
         end else if (u.battery_failsafe) begin
            launch = 1'b1;
            pick   = cfg_single;
         end
      end
      if (launch) begin
         shadow_pattern = pick;
         play_start     = u.now_ms;
      end
      // Play MSB first; an empty pattern holds the last level
      if (shadow_pattern != '0) begin
         elapsed = u.now_ms - play_start;
         if (elapsed >= PLAY_SPAN_MS) begin
            tone_level     = 1'b0;
            shadow_pattern = '0;
         end else begin
            slot = elapsed / BIT_PERIOD_MS;
            if (slot > 31)
               tone_level = 1'b0;
            else
               tone_level = shadow_pattern[5'd31 - slot[4:0]];
         end
      end
      return tone_level;
   endfunction

   function automatic req_payload_type make_update(input logic [TIME_WIDTH-1:0] now,
                                                   input logic fail, input logic arm,
                                                   input logic ekf, input logic lost,
                                                   input logic batt);
      req_payload_type u;
      u.now_ms           = now;
      u.arm_refused      = fail;
      u.armed            = arm;
      u.ekf_bad          = ekf;
      u.lost_alarm       = lost;
      u.battery_failsafe = batt;
      return u;
   endfunction

   function automatic logic [PATTERN_WIDTH-1:0] pick_pattern();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic push_update(input req_payload_type u);
      updates_pending.push_back(u);
      items_sent++;
   endtask

   // Write one register at the next edge and mirror it in the shadow copy
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SINGLE_PATTERN:  cfg_single  = value;
         CSR_ARMING_PATTERN:  cfg_arming  = value;
         CSR_EKF_BAD_PATTERN: cfg_ekf_bad = value;
         CSR_DOUBLE_PATTERN:  cfg_double  = value;
         CSR_MIN_INTERVAL_MS: cfg_min_gap = value[INTERVAL_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Wait until every request has its response, then let the pipeline settle
   task automatic wait_idle();
      while (rsp_seen < items_sent)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Well-formed streams with rising timestamps, plus some random noise
   task automatic queue_stream(input int count);
      req_payload_type       u;
      logic [TIME_WIDTH-1:0] ms;
      logic                  arm_s;
      logic                  ekf_s;
      logic                  lost_s;
      logic                  batt_s;
      int                    k;
      ms = $urandom();
      if ($urandom_range(0, 2) == 0)
         ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      arm_s  = 1'($urandom_range(0, 1));
      ekf_s  = 1'($urandom_range(0, 1));
      lost_s = 1'b0;
      batt_s = 1'b0;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            u.now_ms = $urandom();
            {u.arm_refused, u.armed, u.ekf_bad, u.lost_alarm, u.battery_failsafe} =
               5'($urandom_range(0, 31));
         end else begin
            case ($urandom_range(0, 19))
               0:       ms += $urandom_range(0, 70000);
               1, 2:    ms += $urandom_range(3000, 4000);
               default: ms += $urandom_range(0, 250);
            endcase
            if ($urandom_range(0, 19) == 0) arm_s  = ~arm_s;
            if ($urandom_range(0, 14) == 0) ekf_s  = ~ekf_s;
            if ($urandom_range(0, 24) == 0) lost_s = ~lost_s;
            if ($urandom_range(0, 24) == 0) batt_s = ~batt_s;
            u = make_update(ms, $urandom_range(0, 29) == 0, arm_s, ekf_s, lost_s, batt_s);
         end
         push_update(u);
      end
   endtask

   // Reprogram every register for one phase
   task automatic program_phase(input int phase);
      logic [CSR_DATA_WIDTH-1:0] gap_word;
      gap_word = $urandom();
      case (phase)
         0: gap_word[INTERVAL_WIDTH-1:0] = '0;
         1: gap_word[INTERVAL_WIDTH-1:0] = '1;
         default: gap_word[INTERVAL_WIDTH-1:0] = $urandom_range(0, 4000);
      endcase
      write_reg(CSR_SINGLE_PATTERN,  (phase == 1) ? '0 : ((phase == 0) ? '1 : pick_pattern()));
      write_reg(CSR_ARMING_PATTERN,  (phase == 0) ? '1 : pick_pattern());
      write_reg(CSR_EKF_BAD_PATTERN, (phase == 0) ? '1 : pick_pattern());
      write_reg(CSR_DOUBLE_PATTERN,  (phase == 0) ? '1 : pick_pattern());
      write_reg(CSR_MIN_INTERVAL_MS, gap_word);
      write_reg(CSR_UNUSED_FIRST + 3'($urandom_range(0, 2)), $urandom());
   endtask

   // Driver: present the next queued request, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (updates_pending.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap_left = $urandom_range(0, 18);
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.payload <= updates_pending.pop_front();
            req_ch.valid   <= 1'b1;
         end
      end
   end

   // Response back-pressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 18);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      logic want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready)
            levels_due.push_back(predict_buzzer_level(req_ch.payload));
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (levels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d: unexpected, buzzer_level=%b",
                           rsp_seen, rsp_ch.buzzer_level);
            end else begin
               want = levels_due.pop_front();
               if (rsp_ch.buzzer_level !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("response %0d: buzzer_level expected %b, got %b",
                              rsp_seen, want, rsp_ch.buzzer_level);
               end
            end
         end
         // Watchdog on cycles with no handshake at all
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int p;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_ch.valid     = 1'b0;
      req_ch.payload   = '0;
      rsp_ch.ready     = 1'b0;
      req_taken        = 1'b0;
      items_sent       = 0;
      rsp_seen         = 0;
      mismatches       = 0;
      quiet_cycles     = 0;
      gap_left         = 0;
      stall_left       = 0;
      idle_odds        = 6;
      stall_odds       = 6;
      phases_run       = 0;
      cfg_single       = SINGLE_PATTERN_RESET;
      cfg_arming       = ARMING_PATTERN_RESET;
      cfg_ekf_bad      = EKF_BAD_PATTERN_RESET;
      cfg_double       = DOUBLE_PATTERN_RESET;
      cfg_min_gap      = MIN_INTERVAL_RESET;
      shadow_pattern   = '0;
      play_start       = '0;
      armed_latch      = 1'b0;
      ekf_latch        = 1'b0;
      tone_level       = 1'b0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed walk through every selection rule at reset settings
      push_update(make_update(32'd0,     0, 0, 0, 0, 0));  // too soon, nothing plays
      push_update(make_update(32'd100,   1, 0, 0, 0, 0));  // arming failure overrides
      push_update(make_update(32'd150,   0, 0, 0, 0, 0));
      push_update(make_update(32'd3300,  0, 0, 0, 0, 0));  // span over, stop
      push_update(make_update(32'd5000,  0, 1, 0, 0, 0));  // becoming armed
      push_update(make_update(32'd5500,  0, 1, 1, 0, 0));  // change held off by interval
      push_update(make_update(32'd8400,  0, 1, 1, 0, 0));  // ekf turns bad
      push_update(make_update(32'd8650,  0, 1, 1, 0, 0));
      push_update(make_update(32'd8750,  0, 1, 1, 0, 0));
      push_update(make_update(32'd11800, 0, 0, 1, 0, 0));  // disarmed
      push_update(make_update(32'd15200, 0, 0, 0, 1, 0));  // ekf recovers, lost waits
      push_update(make_update(32'd18600, 0, 0, 0, 1, 0));  // vehicle lost
      push_update(make_update(32'd18700, 0, 0, 0, 1, 0));
      push_update(make_update(32'd22000, 0, 0, 0, 0, 1));  // battery failsafe
      push_update(make_update(32'hFFFF_FF00, 0, 0, 0, 0, 1));
      push_update(make_update(32'h0000_0050, 0, 0, 0, 0, 1));  // time wraps
      push_update(make_update(32'hFFFF_FFFF, 1, 1, 1, 1, 1));  // all flags at once
      push_update(make_update(32'h0000_0C7F, 0, 1, 1, 1, 1));  // exactly 3200 ms later
      push_update(make_update(32'h0000_0C00, 0, 1, 1, 1, 1));  // time runs backward
      push_update(make_update(32'd0,     1, 0, 0, 0, 0));
      push_update(make_update(32'd1,     0, 0, 0, 0, 0));
      wait_idle();

      // Randomized phases, each with its own register settings
      for (p = 0; p < PHASE_COUNT; p++) begin
         program_phase(p);
         phases_run++;
         if (p == PHASE_COUNT - 1) begin
            idle_odds  = 0;
            stall_odds = 0;
         end else begin
            case (p % 3)
               0: begin idle_odds = 4;  stall_odds = 5;  end
               1: begin idle_odds = 12; stall_odds = 0;  end
               default: begin idle_odds = 0; stall_odds = 10; end
            endcase
         end
         queue_stream(PHASE_UPDATES);
         wait_idle();
      end

      $display("covered %0d update requests, %0d responses over %0d register settings",
               items_sent, rsp_seen, phases_run + 1);
      $display("mismatches: %0d, responses still owed: %0d", mismatches, levels_due.size());
      if (mismatches == 0 && levels_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/bpseq_pkg.sv
hdl/bpseq_channels.sv
hdl/buzzer_pattern_sequencer.sv
tb/tb_buzzer_pattern_sequencer.sv
